@@ hdl/stb_pkg.sv @@
`default_nettype none

package stb_pkg;

   localparam logic [1:0] CMD_INIT  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_STOP  = 2'd2;
   localparam logic [1:0] CMD_TICK  = 2'd3;

   localparam logic [1:0] PH_NONE    = 2'd0;
   localparam logic [1:0] PH_CREATED = 2'd1;
   localparam logic [1:0] PH_STARTED = 2'd2;
   localparam logic [1:0] PH_STOPPED = 2'd3;

   localparam int MAX_EVENTS = 16;
   localparam int EVT_W      = 4;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  timer_index;
      logic [31:0] start_delay;
      logic [31:0] period;
      logic        hard_class;
   } req_type;

   typedef struct packed {
      logic [3:0] fired_channel;
      logic       fired_hard;
      logic       fired_last;
   } rsp_type;

   typedef struct packed {
      logic       fire;
      logic       wr_count;
      logic       wr_phase;
      logic [1:0] phase;
   } chan_upd_type;

   typedef struct packed {
      logic found;
      logic hard;
      logic last_in_mask;
   } sel_type;

endpackage

`default_nettype wire

@@ hdl/software_timer_bank.sv @@
// init, start, stop: request passes through the S_CMD state back to idle, no result
// tick: S_WALK walks the channels through one count unit,
//   one channel per cycle over the count memory port, then one result per cycle
//   as the result register drains, while rsp_ready holds (at most 16 results)
// one request at a time; ready again once the last result is loaded, or once none is pending
// reset (synchronous): all channels never initialized, sequencer idle, no clearing pass
`default_nettype none

module software_timer_bank import stb_pkg::*; #(
   parameter int NUM_TIMERS = 16,
   parameter int COUNT_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_TIMERS - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMD  = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]            state_ff, state_in;
   req_type               req_ff, req_in;
   logic [IDX_W-1:0]      walk_ff, walk_in;
   logic [NUM_TIMERS-1:0] pend_ff, pend_in;
   logic [EVT_W-1:0]      emit_cnt_ff, emit_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [1:0]            phase_ff [NUM_TIMERS];
   logic [1:0]            phase_in [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] class_ff, class_in;

   logic                  accept;
   logic [IDX_W-1:0]      cmd_ch;
   logic                  idx_ok;
   logic [1:0]            cmd_phase;
   logic [1:0]            walk_phase;
   logic                  init_ok, start_ok, stop_ok;
   logic [COUNT_BITS-1:0] req_delay, req_period;
   logic [IDX_W-1:0]      rd_addr;
   logic [COUNT_BITS-1:0] rd_delay, rd_period, rd_count;
   logic [COUNT_BITS-1:0] unit_delay, unit_period;
   logic [COUNT_BITS-1:0] first_count, new_count;
   chan_upd_type          upd;
   logic                  prm_we, cnt_we;
   logic [IDX_W-1:0]      cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic [IDX_W-1:0]      sel_idx;
   logic [NUM_TIMERS-1:0] sel_pick;
   sel_type               sel;
   logic                  load_rsp;
   logic                  rsp_last;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign cmd_ch     = IDX_W'(req_ff.timer_index);
   assign idx_ok     = ({28'd0, req_ff.timer_index} < 32'(NUM_TIMERS));
   assign cmd_phase  = phase_ff[cmd_ch];
   assign walk_phase = phase_ff[walk_ff];
   assign req_delay  = COUNT_BITS'(req_ff.start_delay);
   assign req_period = COUNT_BITS'(req_ff.period);

   assign init_ok  = (state_ff == S_CMD) && idx_ok && (req_ff.command == CMD_INIT)
                     && (cmd_phase != PH_STARTED);
   assign start_ok = (state_ff == S_CMD) && idx_ok && (req_ff.command == CMD_START)
                     && ((cmd_phase == PH_CREATED) || (cmd_phase == PH_STOPPED));
   assign stop_ok  = (state_ff == S_CMD) && idx_ok && (req_ff.command == CMD_STOP)
                     && (cmd_phase == PH_STARTED);

   always_comb begin
      rd_addr = '0;
      if (state_ff == S_IDLE) begin
         if (req_data.command != CMD_TICK) begin
            rd_addr = IDX_W'(req_data.timer_index);
         end
      end else if (state_ff == S_WALK) begin
         if (walk_ff != LAST_CH) begin
            rd_addr = walk_ff + IDX_W'(1);
         end
      end
   end

   // init takes its values from the request, everything else from the store
   assign unit_delay  = (req_ff.command == CMD_INIT) ? req_delay : rd_delay;
   assign unit_period = (state_ff == S_CMD && req_ff.command == CMD_INIT) ? req_period
                                                                          : rd_period;

   assign prm_we    = init_ok;
   assign cnt_we    = init_ok || start_ok || ((state_ff == S_WALK) && upd.wr_count);
   assign cnt_waddr = (state_ff == S_WALK) ? walk_ff : cmd_ch;
   assign cnt_wdata = (state_ff == S_WALK) ? new_count : first_count;

   stb_chan_mem #(
      .NUM_TIMERS (NUM_TIMERS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_W      (IDX_W)
   ) u_mem (
      .clock       (clock),
      .prm_we      (prm_we),
      .prm_waddr   (cmd_ch),
      .prm_wdelay  (req_delay),
      .prm_wperiod (req_period),
      .cnt_we      (cnt_we),
      .cnt_waddr   (cnt_waddr),
      .cnt_wdata   (cnt_wdata),
      .rd_addr     (rd_addr),
      .rd_delay    (rd_delay),
      .rd_period   (rd_period),
      .rd_count    (rd_count)
   );

   stb_count_unit #(
      .COUNT_BITS (COUNT_BITS)
   ) u_count (
      .phase       (walk_phase),
      .count       (rd_count),
      .delay       (unit_delay),
      .period      (unit_period),
      .first_count (first_count),
      .new_count   (new_count),
      .upd         (upd)
   );

   stb_event_sel #(
      .NUM_TIMERS (NUM_TIMERS),
      .IDX_W      (IDX_W)
   ) u_sel (
      .pend      (pend_ff),
      .hard_mask (class_ff),
      .sel_idx   (sel_idx),
      .sel_pick  (sel_pick),
      .sel       (sel)
   );

   assign load_rsp = (state_ff == S_EMIT) && sel.found && (!rsp_valid_ff || rsp_ready);
   assign rsp_last = sel.last_in_mask || (emit_cnt_ff == EVT_W'(MAX_EVENTS - 1));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      walk_in      = walk_ff;
      pend_in      = pend_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      phase_in     = phase_ff;
      class_in     = class_ff;

      if (init_ok) begin
         phase_in[cmd_ch] = PH_CREATED;
         class_in[cmd_ch] = req_ff.hard_class;
      end
      if (start_ok) begin
         phase_in[cmd_ch] = PH_STARTED;
      end
      if (stop_ok) begin
         phase_in[cmd_ch] = PH_STOPPED;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               if (req_data.command == CMD_TICK) begin
                  state_in    = S_WALK;
                  walk_in     = '0;
                  pend_in     = '0;
                  emit_cnt_in = '0;
               end else begin
                  state_in = S_CMD;
               end
            end
         end
         S_CMD: begin
            state_in = S_IDLE;
         end
         S_WALK: begin
            if (upd.wr_phase) begin
               phase_in[walk_ff] = upd.phase;
            end
            if (upd.fire) begin
               pend_in[walk_ff] = 1'b1;
            end
            if (walk_ff == LAST_CH) begin
               state_in = S_EMIT;
            end else begin
               walk_in = walk_ff + IDX_W'(1);
            end
         end
         S_EMIT: begin
            if (!sel.found) begin
               state_in = S_IDLE;
            end else if (load_rsp) begin
               rsp_in.fired_channel = 4'(sel_idx);
               rsp_in.fired_hard    = sel.hard;
               rsp_in.fired_last    = rsp_last;
               rsp_valid_in         = 1'b1;
               pend_in              = pend_ff & ~sel_pick;
               emit_cnt_in          = emit_cnt_ff + EVT_W'(1);
               if (rsp_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= '0;
         pend_ff      <= '0;
         emit_cnt_ff  <= '0;
         class_ff     <= '0;
         for (int i = 0; i < NUM_TIMERS; i++) begin
            phase_ff[i] <= PH_NONE;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_ff      <= walk_in;
         pend_ff      <= pend_in;
         emit_cnt_ff  <= emit_cnt_in;
         class_ff     <= class_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_fire_only_started: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && upd.fire) |-> (walk_phase == PH_STARTED))
      else $error("fire from a channel that is not started");

   a_walk_ends_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && walk_ff == LAST_CH) |=> (state_ff == S_EMIT))
      else $error("walk did not hand over to emit");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && rsp_last) |=> (state_ff == S_IDLE && rsp_valid_ff && rsp_ff.fired_last))
      else $error("last event did not end the tick");
`endif

endmodule

`default_nettype wire

@@ hdl/stb_chan_mem.sv @@
`default_nettype none

module stb_chan_mem #(
   parameter int NUM_TIMERS = 16,
   parameter int COUNT_BITS = 32,
   parameter int IDX_W      = 4
) (
   input  logic                  clock,
   input  logic                  prm_we,
   input  logic [IDX_W-1:0]      prm_waddr,
   input  logic [COUNT_BITS-1:0] prm_wdelay,
   input  logic [COUNT_BITS-1:0] prm_wperiod,
   input  logic                  cnt_we,
   input  logic [IDX_W-1:0]      cnt_waddr,
   input  logic [COUNT_BITS-1:0] cnt_wdata,
   input  logic [IDX_W-1:0]      rd_addr,
   output logic [COUNT_BITS-1:0] rd_delay,
   output logic [COUNT_BITS-1:0] rd_period,
   output logic [COUNT_BITS-1:0] rd_count
);

   logic [2*COUNT_BITS-1:0] prm_mem [NUM_TIMERS];
   logic [COUNT_BITS-1:0]   count_mem [NUM_TIMERS];
   logic [2*COUNT_BITS-1:0] rd_prm_ff;
   logic [COUNT_BITS-1:0]   rd_count_ff;

   always_ff @(posedge clock) begin
      if (prm_we) begin
         prm_mem[prm_waddr] <= {prm_wdelay, prm_wperiod};
      end
      rd_prm_ff <= prm_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
      rd_count_ff <= count_mem[rd_addr];
   end

   assign rd_delay  = rd_prm_ff[2*COUNT_BITS-1:COUNT_BITS];
   assign rd_period = rd_prm_ff[COUNT_BITS-1:0];
   assign rd_count  = rd_count_ff;

endmodule

`default_nettype wire

@@ hdl/stb_count_unit.sv @@
`default_nettype none

module stb_count_unit import stb_pkg::*; #(
   parameter int COUNT_BITS = 32
) (
   input  logic [1:0]            phase,
   input  logic [COUNT_BITS-1:0] count,
   input  logic [COUNT_BITS-1:0] delay,
   input  logic [COUNT_BITS-1:0] period,
   output logic [COUNT_BITS-1:0] first_count,
   output logic [COUNT_BITS-1:0] new_count,
   output chan_upd_type          upd
);

   logic [COUNT_BITS-1:0] dec;
   logic                  at_end;

   always_comb begin
      first_count = (delay != '0) ? delay : period;
      dec         = count - COUNT_BITS'(1);
      at_end      = (count[COUNT_BITS-1:1] == '0);
      new_count   = dec;
      upd         = '0;
      upd.phase   = phase;
      if (phase == PH_STARTED) begin
         upd.wr_count = 1'b1;
         if (at_end) begin
            upd.fire = 1'b1;
            if (period != '0) begin
               new_count = period;
            end else begin
               new_count    = '0;
               upd.wr_phase = 1'b1;
               upd.phase    = PH_STOPPED;
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/stb_event_sel.sv @@
`default_nettype none

module stb_event_sel import stb_pkg::*; #(
   parameter int NUM_TIMERS = 16,
   parameter int IDX_W      = 4
) (
   input  logic [NUM_TIMERS-1:0] pend,
   input  logic [NUM_TIMERS-1:0] hard_mask,
   output logic [IDX_W-1:0]      sel_idx,
   output logic [NUM_TIMERS-1:0] sel_pick,
   output sel_type               sel
);

   logic [NUM_TIMERS-1:0] hard_pend;
   logic [NUM_TIMERS-1:0] soft_pend;
   logic [NUM_TIMERS-1:0] cand;

   always_comb begin
      hard_pend = pend & hard_mask;
      soft_pend = pend & ~hard_mask;
      sel.found = |pend;
      sel.hard  = |hard_pend;
      cand      = sel.hard ? hard_pend : soft_pend;
      sel_pick  = cand & (~cand + NUM_TIMERS'(1));
      sel_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            sel_idx = IDX_W'(i);
         end
      end
      sel.last_in_mask = ((pend & ~sel_pick) == '0);
   end

endmodule

`default_nettype wire
